/* src/matrix_inverse_3x3_top_assert.svh */
// Assertion macros used by the matrix inverse controller.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef MATRIX_INVERSE_3X3_TOP_ASSERT_SVH
`define MATRIX_INVERSE_3X3_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MI3_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define MI3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/mi3_pkg.sv */
// Types and constants for the matrix inverse block.
// No dependencies.
package mi3_pkg;

  localparam int DW = 32;
  localparam int MW = 49;
  localparam logic [DW-1:0] FX_ONE = 32'h0001_0000;

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_PIV_RD, S_PIV_CAP, S_PIV_CHK,
    S_SW_RD, S_SW_CAP, S_SW_W1, S_SW_W2, S_RECIP,
    S_X_RD, S_X_CAP, S_OP_RD, S_OP_CAP, S_OP_MUL, S_OP_RND, S_OP_WR,
    S_OUT_RD, S_OUT_CAP, S_OUT_SHOW, S_SING
  } state_t;

  typedef enum logic [2:0] {
    WS_IN, WS_ONE, WS_ZERO, WS_HOLDA, WS_HOLDB, WS_SCALE, WS_ELIM
  } wsel_t;

  typedef struct packed {
    logic  we;
    logic  wr_to_b;
    wsel_t wsel;
    logic  cap;
    logic  xcap;
    logic  recip_start;
    logic  use_recip;
    logic  out_cap;
    logic  out_clr;
  } cmd_t;

  typedef struct packed {
    logic piv_zero;
    logic recip_done;
  } stat_t;

  // Saturate a magnitude with sign to a DW-bit two's complement word.
  function automatic logic [DW-1:0] sat_mag(input logic neg, input logic [MW-1:0] m);
    logic [MW-1:0] lim;
    logic [MW-1:0] mm;
    lim = neg ? (MW'(1) << (DW - 1)) : ((MW'(1) << (DW - 1)) - MW'(1));
    mm = (m > lim) ? lim : m;
    return neg ? (DW'(0) - mm[DW-1:0]) : mm[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] a);
    return a[DW-1] ? (DW'(0) - a) : a;
  endfunction

  // Saturating difference a - b.
  function automatic logic [DW-1:0] sat_sub(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic signed [DW:0] d;
    d = $signed({a[DW-1], a}) - $signed({b[DW-1], b});
    if (d[DW] != d[DW-1]) begin
      return d[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    return d[DW-1:0];
  endfunction

endpackage

/* src/matrix_inverse_3x3_top.sv */
// Top level of the Gauss-Jordan matrix inverse block.
// Depends on mi3_pkg, mi3_ctrl and mi3_datapath.
//
// This block inverts a DIM x DIM matrix of signed Q16.16 values. Requests carry
// one element each, in row-major order; the request with the last element
// starts the inversion. While an inversion runs the block takes no request.
// For each column the pivot row is swapped downward while the pivot is zero,
// scaled by a rounded reciprocal of the pivot, and used to clear the rows
// below; the rows above each pivot are then cleared, last column first. All
// products round to nearest with ties away from zero, and every result
// saturates. The nine inverse elements leave in row-major order with row and
// col tags and last on the final one; a matrix whose pivot stays zero yields
// a single result with singular and last set and a value of zero. While
// loading, in_ready stays high, so a request is taken whenever one is
// offered. A run writes the identity, reads, captures and checks each pivot,
// swaps rows element by element over both matrices by a read, a capture and
// a write to each row, and forms each reciprocal in a bit-serial divider, one
// quotient bit per cycle. Each element of a row operation is read, captured,
// multiplied, rounded and written back through the shared multiplier and the
// single write port of the matrix memory, which holds both matrices; each
// elimination first fetches its multiplier. Results wait for out_ready.
module matrix_inverse_3x3_top
  import mi3_pkg::*;
#(
  parameter int DIM = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [DW-1:0] element,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [DW-1:0] value,
  output logic [1:0]           row,
  output logic [1:0]           col,
  output logic                 singular,
  output logic                 last
);

  localparam int DEPTH = 2 * DIM * DIM;
  localparam int AW = $clog2(DEPTH);

  cmd_t          cmd;
  stat_t         stat;
  logic [AW-1:0] addr_a, addr_b;

  mi3_ctrl #(.DIM(DIM), .AW(AW)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .row(row), .col(col), .singular(singular), .last(last),
    .cmd(cmd), .stat(stat), .addr_a(addr_a), .addr_b(addr_b)
  );

  mi3_datapath #(.AW(AW), .DEPTH(DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .addr_a(addr_a), .addr_b(addr_b),
    .element(element), .stat(stat), .value(value)
  );

endmodule

/* src/mi3_ram.sv */
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module mi3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 18
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* src/mi3_datapath.sv */
// Datapath: matrix store, serial reciprocal, multiplier pipeline, output register.
// Depends on mi3_pkg and mi3_ram.
module mi3_datapath
  import mi3_pkg::*;
#(
  parameter int AW = 5,
  parameter int DEPTH = 18
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic [AW-1:0]        addr_a,
  input  logic [AW-1:0]        addr_b,
  input  logic signed [DW-1:0] element,
  output stat_t                stat,
  output logic signed [DW-1:0] value
);

  logic [DW-1:0] qa, qb, opa, opb, xval, rval, mres, wdata, outv;
  logic [DW-1:0] dsor, ma, mb;
  logic [DW:0]   nsh, rem, trial, quo;
  logic [5:0]    rcnt;
  logic          rneg, pneg;
  logic [2*DW-1:0] prod, rsum;

  mi3_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(cmd.we), .waddr(cmd.wr_to_b ? addr_b : addr_a), .wdata(wdata),
    .raddr_a(addr_a), .raddr_b(addr_b), .rdata_a(qa), .rdata_b(qb)
  );

  always_comb begin
    case (cmd.wsel)
      WS_IN:    wdata = element;
      WS_ONE:   wdata = FX_ONE;
      WS_ZERO:  wdata = '0;
      WS_HOLDA: wdata = opa;
      WS_HOLDB: wdata = opb;
      WS_SCALE: wdata = mres;
      WS_ELIM:  wdata = sat_sub(opa, mres);
      default:  wdata = '0;
    endcase
  end

  // Restoring divider for (2^32 + |p|/2) / |p|, one quotient bit per cycle.
  // The quotient keeps all 33 bits so that a pivot of one LSB saturates.
  assign trial = {rem[DW-1:0], nsh[DW]};

  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt <= '0;
    end else if (cmd.recip_start) begin
      rcnt <= 6'(DW + 1);
    end else if (rcnt != '0) begin
      rcnt <= rcnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.recip_start) begin
      dsor <= mag_of(opa);
      rneg <= opa[DW-1];
      nsh  <= {1'b1, mag_of(opa) >> 1};
      rem  <= '0;
      quo  <= '0;
    end else if (rcnt != '0) begin
      nsh <= nsh << 1;
      if (trial >= {1'b0, dsor}) begin
        rem <= trial - {1'b0, dsor};
        quo <= {quo[DW-1:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[DW-1:0], 1'b0};
      end
    end
    rval <= sat_mag(rneg, MW'(quo));
  end

  // Operand capture, multiply, then round and saturate.
  assign ma = cmd.use_recip ? mag_of(opa) : mag_of(opb);
  assign mb = cmd.use_recip ? mag_of(rval) : mag_of(xval);
  assign rsum = prod + (2*DW)'(32768);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      opa <= qa;
      opb <= qb;
    end
    if (cmd.xcap) begin
      xval <= qa;
    end
    prod <= ma * mb;
    pneg <= (cmd.use_recip ? opa[DW-1] : opb[DW-1]) ^
            (cmd.use_recip ? rval[DW-1] : xval[DW-1]);
    mres <= sat_mag(pneg, MW'(rsum >> 16));
    if (cmd.out_clr) begin
      outv <= '0;
    end else if (cmd.out_cap) begin
      outv <= qa;
    end
  end

  assign stat.piv_zero   = (opa == '0);
  assign stat.recip_done = (rcnt == '0);
  assign value = outv;

endmodule

/* src/mi3_ctrl.sv */
// Controller state machine: sequences loading, pivoting, elimination and output.
// Depends on mi3_pkg and the assertion header.
`include "matrix_inverse_3x3_top_assert.svh"
module mi3_ctrl
  import mi3_pkg::*;
#(
  parameter int DIM = 3,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    row,
  output logic [1:0]    col,
  output logic          singular,
  output logic          last,
  output cmd_t          cmd,
  input  stat_t         stat,
  output logic [AW-1:0] addr_a,
  output logic [AW-1:0] addr_b
);

  localparam int CELLS = DIM * DIM;
  localparam int IW = $clog2(DIM + 1);
  localparam logic [IW-1:0] DIM_I = IW'(DIM);
  localparam logic [IW-1:0] LAST_I = IW'(DIM - 1);

  state_t state, state_next;
  logic [IW-1:0] k, k_next, j, j_next, c, c_next;
  logic m, m_next, back, back_next, op_scale, op_scale_next;
  logic [IW-1:0] a_row, a_col;
  logic a_mat, pass_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      k <= '0;
      j <= '0;
      c <= '0;
      m <= 1'b0;
      back <= 1'b0;
      op_scale <= 1'b0;
    end else begin
      state <= state_next;
      k <= k_next;
      j <= j_next;
      c <= c_next;
      m <= m_next;
      back <= back_next;
      op_scale <= op_scale_next;
    end
  end

  assign pass_end = m && (c == LAST_I);

  always_comb begin
    state_next = state;
    k_next = k;
    j_next = j;
    c_next = c;
    m_next = m;
    back_next = back;
    op_scale_next = op_scale;
    cmd = '0;
    cmd.wsel = WS_IN;
    cmd.use_recip = op_scale;
    unique case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.we = 1'b1;
          c_next = (c == LAST_I) ? '0 : c + 1'b1;
          j_next = (c == LAST_I) ? j + 1'b1 : j;
          if (j == LAST_I && c == LAST_I) begin
            j_next = '0;
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.we = 1'b1;
        cmd.wsel = (j == c) ? WS_ONE : WS_ZERO;
        c_next = (c == LAST_I) ? '0 : c + 1'b1;
        j_next = (c == LAST_I) ? j + 1'b1 : j;
        if (j == LAST_I && c == LAST_I) begin
          k_next = '0;
          j_next = IW'(1);
          state_next = S_PIV_RD;
        end
      end
      S_PIV_RD: state_next = S_PIV_CAP;
      S_PIV_CAP: begin
        cmd.cap = 1'b1;
        state_next = S_PIV_CHK;
      end
      S_PIV_CHK: begin
        if (!stat.piv_zero) begin
          cmd.recip_start = 1'b1;
          state_next = S_RECIP;
        end else if (j < DIM_I) begin
          m_next = 1'b0;
          c_next = '0;
          state_next = S_SW_RD;
        end else begin
          cmd.out_clr = 1'b1;
          state_next = S_SING;
        end
      end
      S_SW_RD: state_next = S_SW_CAP;
      S_SW_CAP: begin
        cmd.cap = 1'b1;
        state_next = S_SW_W1;
      end
      S_SW_W1: begin
        cmd.we = 1'b1;
        cmd.wsel = WS_HOLDB;
        state_next = S_SW_W2;
      end
      S_SW_W2: begin
        cmd.we = 1'b1;
        cmd.wr_to_b = 1'b1;
        cmd.wsel = WS_HOLDA;
        c_next = (c == LAST_I) ? '0 : c + 1'b1;
        m_next = (c == LAST_I) ? ~m : m;
        state_next = S_SW_RD;
        if (pass_end) begin
          j_next = j + 1'b1;
          state_next = S_PIV_RD;
        end
      end
      S_RECIP: begin
        if (stat.recip_done) begin
          op_scale_next = 1'b1;
          m_next = 1'b0;
          c_next = '0;
          state_next = S_OP_RD;
        end
      end
      S_X_RD: state_next = S_X_CAP;
      S_X_CAP: begin
        cmd.xcap = 1'b1;
        state_next = S_OP_RD;
      end
      S_OP_RD: state_next = S_OP_CAP;
      S_OP_CAP: begin
        cmd.cap = 1'b1;
        state_next = S_OP_MUL;
      end
      S_OP_MUL: state_next = S_OP_RND;
      S_OP_RND: state_next = S_OP_WR;
      S_OP_WR: begin
        cmd.we = 1'b1;
        cmd.wsel = op_scale ? WS_SCALE : WS_ELIM;
        c_next = (c == LAST_I) ? '0 : c + 1'b1;
        m_next = (c == LAST_I) ? ~m : m;
        state_next = S_OP_RD;
        if (pass_end) begin
          op_scale_next = 1'b0;
          state_next = S_X_RD;
          if (back) begin
            // Upward pass: rows above pivot k, nearest first, last pivot first.
            if (j == '0) begin
              if (k == IW'(1)) begin
                j_next = '0;
                state_next = S_OUT_RD;
              end else begin
                k_next = k - 1'b1;
                j_next = k - IW'(2);
              end
            end else begin
              j_next = j - 1'b1;
            end
          end else if ((op_scale ? k : j) + 1'b1 < DIM_I) begin
            j_next = (op_scale ? k : j) + 1'b1;
          end else if (k + 1'b1 < DIM_I) begin
            k_next = k + 1'b1;
            j_next = k + IW'(2);
            state_next = S_PIV_RD;
          end else begin
            back_next = 1'b1;
            k_next = LAST_I;
            j_next = LAST_I - 1'b1;
          end
        end
      end
      S_OUT_RD: state_next = S_OUT_CAP;
      S_OUT_CAP: begin
        cmd.out_cap = 1'b1;
        state_next = S_OUT_SHOW;
      end
      S_OUT_SHOW: begin
        if (out_ready) begin
          c_next = (c == LAST_I) ? '0 : c + 1'b1;
          j_next = (c == LAST_I) ? j + 1'b1 : j;
          state_next = S_OUT_RD;
          if (j == LAST_I && c == LAST_I) begin
            j_next = '0;
            back_next = 1'b0;
            state_next = S_LOAD;
          end
        end
      end
      S_SING: begin
        if (out_ready) begin
          j_next = '0;
          c_next = '0;
          back_next = 1'b0;
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // Port A addresses the row read or written; port B the pivot row.
  always_comb begin
    a_row = j;
    a_col = c;
    a_mat = 1'b0;
    unique case (state)
      S_PIV_RD, S_PIV_CAP, S_PIV_CHK: begin
        a_row = k;
        a_col = k;
      end
      S_X_RD, S_X_CAP: a_col = k;
      S_SW_RD, S_SW_CAP, S_SW_W1, S_SW_W2: a_mat = m;
      S_OP_RD, S_OP_CAP, S_OP_MUL, S_OP_RND, S_OP_WR: begin
        a_mat = m;
        a_row = op_scale ? k : j;
      end
      S_INIT, S_OUT_RD, S_OUT_CAP, S_OUT_SHOW: a_mat = 1'b1;
      default: a_mat = 1'b0;
    endcase
  end

  assign addr_a = AW'(int'(a_mat) * CELLS + int'(a_row) * DIM + int'(a_col));
  assign addr_b = AW'(int'(m) * CELLS + int'(k) * DIM + int'(c));

  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_OUT_SHOW) || (state == S_SING);
  assign singular  = (state == S_SING);
  assign last      = singular || (j == LAST_I && c == LAST_I);
  assign row       = singular ? 2'd0 : 2'(j);
  assign col       = singular ? 2'd0 : 2'(c);

  `MI3_ASSERT_NOW(a_no_overlap, in_ready, !out_valid)
  `MI3_ASSERT_NOW(a_sing_last, out_valid && singular, last)
  `MI3_ASSERT_NEXT(a_recip_to_op, state == S_RECIP && stat.recip_done, state == S_OP_RD)

endmodule
